### rtl/gb5_pkg.sv
// Shared types, constants and kernel table for the 5x5 Gaussian blur block.
`default_nettype none

package gb5_pkg;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 12;
  localparam int POS_W  = 11;
  localparam int KDIM   = 5;
  localparam int LINES  = KDIM - 1;
  localparam int MIN_DIM = 5;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Register reset values
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

  // APB port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  // Arithmetic widths: row sum <= 134*255, total <= 330*255
  localparam int ROW_SUM_W = 16;
  localparam int ACC_W     = 17;
  localparam logic [ACC_W-1:0] ACC_MAX = 17'd84150;

  // Divide by 330: q = (acc * M) >> 26, exact for acc < 2^17
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_M = 18'd203361;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [5:0]       weight_t;

  // Window indexed [row][col]; row 0 is the oldest line, col 0 the oldest pixel
  typedef pixel_t [KDIM-1:0][KDIM-1:0] window_t;

  localparam weight_t GAUSS_W [KDIM][KDIM] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd20, 6'd33, 6'd20, 6'd4},
    '{6'd7, 6'd33, 6'd54, 6'd33, 6'd7},
    '{6'd4, 6'd20, 6'd33, 6'd20, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
  } cfg_t;

  // Per-word control traveling alongside the window
  typedef struct packed {
    logic             valid;
    logic             produce;
    logic [POS_W-1:0] center_col;
    logic [POS_W-1:0] center_row;
  } win_ctl_t;

endpackage

`default_nettype wire

### rtl/gb5_if.sv
// Valid/ready stream interfaces for pixel input and blurred result output.
`default_nettype none

interface gb5_pix_if;
  logic                      valid;
  logic                      ready;
  logic [gb5_pkg::PIX_W-1:0] gray_pixel;
  logic                      frame_start;

  modport source (output valid, output gray_pixel, output frame_start, input ready);
  modport sink   (input valid, input gray_pixel, input frame_start, output ready);
endinterface

interface gb5_res_if;
  logic                      valid;
  logic                      ready;
  logic [gb5_pkg::PIX_W-1:0] blurred_pixel;
  logic [gb5_pkg::POS_W-1:0] center_col;
  logic [gb5_pkg::POS_W-1:0] center_row;

  modport source (output valid, output blurred_pixel, output center_col, output center_row,
                  input ready);
  modport sink   (input valid, input blurred_pixel, input center_col, input center_row,
                  output ready);
endinterface

`default_nettype wire

### rtl/gb5_cfg_regs.sv
// APB configuration registers: image width and height.
`default_nettype none

module gb5_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gb5_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [gb5_pkg::PDATA_W-1:0]   pwdata,
  output      logic [gb5_pkg::PDATA_W-1:0]   prdata,
  output      logic                          pready,
  output      gb5_pkg::cfg_t                 cfg
);

  logic wr_en;
  logic [0:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= gb5_pkg::RESET_WIDTH;
      cfg.image_height <= gb5_pkg::RESET_HEIGHT;
    end else if (wr_en) begin
      case (reg_sel)
        gb5_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[gb5_pkg::CFG_W-1:0];
        gb5_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[gb5_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      gb5_pkg::REG_IMAGE_WIDTH:  prdata = gb5_pkg::PDATA_W'(cfg.image_width);
      gb5_pkg::REG_IMAGE_HEIGHT: prdata = gb5_pkg::PDATA_W'(cfg.image_height);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/gb5_window.sv
// Raster counters, four-line store memory and the 5x5 pixel window.
`default_nettype none

module gb5_window #(
  parameter int MAX_WIDTH  = gb5_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb5_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire gb5_pkg::cfg_t cfg,
  input  wire logic         adv,
  gb5_pix_if.sink           pix,
  output gb5_pkg::win_ctl_t ctl,
  output gb5_pkg::window_t  win
);

  localparam int PIX_W = gb5_pkg::PIX_W;
  localparam int KDIM  = gb5_pkg::KDIM;
  localparam int LINES = gb5_pkg::LINES;
  localparam int POS_W = gb5_pkg::POS_W;
  localparam int CFG_W = gb5_pkg::CFG_W;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WL    = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HL    = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int LW    = LINES * PIX_W;

  // Position counters
  logic [CW-1:0] column_count, column_count_next, col_cur;
  logic [RW-1:0] row_count, row_count_next, row_cur;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [WL-1:0] w_lim;
  logic [HL-1:0] h_lim;
  logic          accept;
  logic          produce;

  // Stage 1: line store read in flight
  logic                s1_valid;
  logic [PIX_W-1:0]    s1_pix;
  logic [CW-1:0]       s1_col;
  logic                s1_produce;
  logic [POS_W-1:0]    s1_cc, s1_cr;
  logic                s1_fwd;
  logic [LW-1:0]       s1_fwd_data;

  // Line store: one entry per column, four lines packed side by side
  logic [LW-1:0]       line_mem [MAX_WIDTH];
  logic [LW-1:0]       mem_q;
  logic [LW-1:0]       rd_lines;
  logic [LW-1:0]       wr_data;
  gb5_pkg::pixel_t     newcol [KDIM];

  assign pix.ready = adv;
  assign accept    = pix.valid && adv;

  // Clamp configured dimensions
  always_comb begin
    if (cfg.image_width < CFG_W'(gb5_pkg::MIN_DIM)) begin
      w_lim = WL'(gb5_pkg::MIN_DIM);
    end else if (WL'(cfg.image_width) > WL'(MAX_WIDTH)) begin
      w_lim = WL'(MAX_WIDTH);
    end else begin
      w_lim = WL'(cfg.image_width);
    end
    if (cfg.image_height < CFG_W'(gb5_pkg::MIN_DIM)) begin
      h_lim = HL'(gb5_pkg::MIN_DIM);
    end else if (HL'(cfg.image_height) > HL'(MAX_HEIGHT)) begin
      h_lim = HL'(MAX_HEIGHT);
    end else begin
      h_lim = HL'(cfg.image_height);
    end
  end

  // Current position and next counter values
  always_comb begin
    col_cur = pix.frame_start ? '0 : column_count;
    row_cur = pix.frame_start ? '0 : row_count;
    col_inc = {1'b0, col_cur} + 1'b1;
    row_inc = {1'b0, row_cur} + 1'b1;
    produce = (col_cur >= CW'(KDIM - 1)) && (row_cur >= RW'(KDIM - 1));
    if (WL'(col_inc) >= w_lim) begin
      column_count_next = '0;
      row_count_next    = (HL'(row_inc) >= h_lim) ? '0 : row_inc[RW-1:0];
    end else begin
      column_count_next = col_inc[CW-1:0];
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Line store data for the word in stage 1, with bypass of the write just made
  always_comb begin
    rd_lines = s1_fwd ? s1_fwd_data : mem_q;
    wr_data  = {s1_pix, rd_lines[LW-1:PIX_W]};
    for (int r = 0; r < LINES; r++) begin
      newcol[r] = rd_lines[r*PIX_W +: PIX_W];
    end
    newcol[LINES] = s1_pix;
  end

  // Line store read and write
  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q <= line_mem[col_cur];
    end
    if (adv && s1_valid) begin
      line_mem[s1_col] <= wr_data;
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pix.valid;
    end
    if (adv) begin
      s1_pix      <= pix.gray_pixel;
      s1_col      <= col_cur;
      s1_produce  <= produce;
      s1_cc       <= POS_W'(col_cur - CW'(2));
      s1_cr       <= POS_W'(row_cur - RW'(2));
      s1_fwd      <= s1_valid && (s1_col == col_cur);
      s1_fwd_data <= wr_data;
    end
  end

  // Window shift: new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (adv && s1_valid) begin
      for (int r = 0; r < KDIM; r++) begin
        for (int c = 0; c < KDIM - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
        win[r][KDIM-1] <= newcol[r];
      end
    end
  end

  // Stage 2 control, aligned with the shifted window
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl.valid <= s1_valid;
    end
    if (adv) begin
      ctl.produce    <= s1_produce;
      ctl.center_col <= s1_cc;
      ctl.center_row <= s1_cr;
    end
  end

  a_frame_start_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && pix.frame_start) |=> (column_count == CW'(1) && row_count == '0))
    else $error("counters did not restart at frame start");

  a_no_border_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !pix.frame_start && column_count < CW'(KDIM - 1)) |=> !s1_produce)
    else $error("result flagged for a border column");

  a_bypass_needs_writer: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid && s1_col == col_cur) |=> s1_fwd)
    else $error("line store bypass missed a same-column write");

endmodule

`default_nettype wire

### rtl/gb5_filter.sv
// Kernel weighting, sum, divide by 330 and the result output register.
`default_nettype none

module gb5_filter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gb5_pkg::win_ctl_t ctl,
  input  wire gb5_pkg::window_t  win,
  output      logic              adv,
  gb5_res_if.source              res
);

  localparam int KDIM      = gb5_pkg::KDIM;
  localparam int POS_W     = gb5_pkg::POS_W;
  localparam int PIX_W     = gb5_pkg::PIX_W;
  localparam int ROW_SUM_W = gb5_pkg::ROW_SUM_W;
  localparam int ACC_W     = gb5_pkg::ACC_W;
  localparam int PROD_W    = gb5_pkg::ACC_W + gb5_pkg::RECIP_W;

  logic [ROW_SUM_W-1:0] row_sum [KDIM];
  logic [ACC_W-1:0]     acc_next;
  logic [PROD_W-1:0]    quot_prod;

  // Stage 3: row sums
  logic                 s3_valid, s3_produce;
  logic [POS_W-1:0]     s3_cc, s3_cr;
  logic [ROW_SUM_W-1:0] s3_row [KDIM];

  // Stage 4: full weighted sum
  logic                 s4_valid, s4_produce;
  logic [POS_W-1:0]     s4_cc, s4_cr;
  logic [ACC_W-1:0]     s4_acc;

  // Output register
  logic                 out_valid;
  logic [PIX_W-1:0]     out_pix;
  logic [POS_W-1:0]     out_cc, out_cr;

  // Whole pipeline moves when the output register is free or being taken
  assign adv = !out_valid || res.ready;

  // Weighted row sums over the window
  always_comb begin
    for (int r = 0; r < KDIM; r++) begin
      row_sum[r] = '0;
      for (int c = 0; c < KDIM; c++) begin
        row_sum[r] = row_sum[r] +
                     ROW_SUM_W'(win[r][c]) * ROW_SUM_W'(gb5_pkg::GAUSS_W[r][c]);
      end
    end
  end

  // Total of row sums
  always_comb begin
    acc_next = '0;
    for (int r = 0; r < KDIM; r++) begin
      acc_next = acc_next + ACC_W'(s3_row[r]);
    end
  end

  // Divide by 330 through reciprocal multiply
  assign quot_prod = PROD_W'(s4_acc) * PROD_W'(gb5_pkg::RECIP_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s3_valid  <= ctl.valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid && s4_produce;
    end
    if (adv) begin
      s3_produce <= ctl.produce;
      s3_cc      <= ctl.center_col;
      s3_cr      <= ctl.center_row;
      s3_row     <= row_sum;
      s4_produce <= s3_produce;
      s4_cc      <= s3_cc;
      s4_cr      <= s3_cr;
      s4_acc     <= acc_next;
      out_pix    <= quot_prod[gb5_pkg::RECIP_SHIFT +: PIX_W];
      out_cc     <= s4_cc;
      out_cr     <= s4_cr;
    end
  end

  assign res.valid         = out_valid;
  assign res.blurred_pixel = out_pix;
  assign res.center_col    = out_cc;
  assign res.center_row    = out_cr;

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (adv && s4_valid && s4_produce) |=> res.valid)
    else $error("finished word did not reach the output register");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (adv && !(s4_valid && s4_produce)) |=> !res.valid)
    else $error("result shown without a producing word");

  // Border words may carry line store entries not yet written this frame
  a_sum_in_range: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && s4_produce) |-> (s4_acc <= gb5_pkg::ACC_MAX))
    else $error("weighted sum exceeds the kernel bound");

endmodule

`default_nettype wire

### rtl/gaussian_blur_5x5.sv
// 5x5 Gaussian blur over a raster stream of 8-bit gray pixels.
//
// Pixels enter on the "pixels" stream (valid/ready), one word per pixel in
// raster order; frame_start marks the first pixel of a frame and restarts the
// column and row counters. For each pixel at column x >= 4 and row y >= 4 one
// word leaves on the "blurred" stream carrying the kernel-weighted window
// divided by 330 and the window centre (x-2, y-2); border pixels give none.
// Image width and height are set through the APB port (offsets 0x0 and 0x4)
// while the block is idle; values below 5 act as 5, above the maximum as the
// maximum.
// Throughput is one pixel per clock while no stall holds the pipeline. On the
// way from input acceptance to the output, the line store read happens at the
// accepting edge, then window shift, row sums, total and divide follow. The line
// store is a single memory, one 32-bit entry per column, with the write of the
// previous pixel bypassed into a read of the same column.
// Reset clears counters, window and pipeline valids; no clearing pass runs.
// When the receiver holds ready low with a result waiting, the whole pipeline
// stalls and ready on the input drops in the same cycle.
`default_nettype none

module gaussian_blur_5x5 #(
  parameter int MAX_WIDTH  = gb5_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb5_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gb5_pkg::PADDR_W-1:0] paddr,
  input  wire logic [gb5_pkg::PDATA_W-1:0] pwdata,
  output      logic [gb5_pkg::PDATA_W-1:0] prdata,
  output      logic                        pready,
  gb5_pix_if.sink                          pixels,
  gb5_res_if.source                        blurred
);

  gb5_pkg::cfg_t     cfg;
  gb5_pkg::win_ctl_t ctl;
  gb5_pkg::window_t  win;
  logic              adv;

  // Configuration registers
  gb5_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Counters, line store and window
  gb5_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .adv (adv),
    .pix (pixels),
    .ctl (ctl),
    .win (win)
  );

  // Weighting, divide and output register
  gb5_filter u_filter (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .win (win),
    .adv (adv),
    .res (blurred)
  );

endmodule

`default_nettype wire
